>>> sv/mafr_pkg.sv
// Package for the multidrop address-frame receiver.
// Holds the receive phase, target and register index codes and the CSR struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mafr_pkg;

   // Receive phase of the frame state machine.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FRAME = 2'd1,
      PH_POLL  = 2'd2,
      PH_WAIT  = 2'd3
   } phase_type;

   // Station that the current frame or poll is addressed to.
   typedef enum logic [1:0] {
      TGT_PRIMARY = 2'd0,
      TGT_AUX     = 2'd1,
      TGT_BCAST   = 2'd2
   } target_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PRIMARY_ADDRESS = 2'd0,
      CSR_AUX_ADDRESS     = 2'd1,
      CSR_BCAST_ADDR      = 2'd2,
      CSR_END_FLAG        = 2'd3
   } csr_index_type;

   // Request kinds.
   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Bit that turns a station address into its poll address.
   localparam logic [7:0] POLL_BIT = 8'h80;

   // Configuration register contents, handed from the CSR block to the receiver.
   typedef struct packed {
      logic [6:0] primary_address;
      logic [6:0] aux_address;
      logic [7:0] bcast_addr;
      logic [7:0] end_flag;
   } csr_type;

endpackage

`default_nettype wire

>>> sv/mafr_csr.sv
// Configuration registers of the multidrop address-frame receiver.
// Depends on mafr_pkg for the register indexes and the csr_type struct.
`timescale 1ns / 1ps
`default_nettype none

module mafr_csr
   import mafr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [7:0]    csr_wdata,
   output csr_type            csr_out
);

   csr_type regs_ff;
   csr_type regs_in;

   // Decode a write into the addressed register; wider data is truncated.
   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PRIMARY_ADDRESS: regs_in.primary_address = csr_wdata[6:0];
            CSR_AUX_ADDRESS:     regs_in.aux_address     = csr_wdata[6:0];
            CSR_BCAST_ADDR:      regs_in.bcast_addr      = csr_wdata;
            CSR_END_FLAG:        regs_in.end_flag        = csr_wdata;
            default:             regs_in = regs_ff;
         endcase
      end
   end

   // All registers reset to zero, which also disables the auxiliary address.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_out = regs_ff;

endmodule

`default_nettype wire

>>> sv/multidrop_address_frame_receiver.sv
// Multidrop address-frame receiver: one result per request, one request per clock
// while the result register can take it. Each request is handled in the cycle it is
// accepted and its result is held in a single output register; a new request is
// taken whenever that register is empty or is being emptied in the same cycle, so
// the rate is one request per cycle while responses are taken. Configuration is
// written through the csr_ port and should only change while no request is pending.
// Depends on mafr_pkg and mafr_csr.
`timescale 1ns / 1ps
`default_nettype none

module multidrop_address_frame_receiver
   import mafr_pkg::*;
#(
   parameter int BUF_SIZE = 256
) (
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [7:0]    csr_wdata,

   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_kind,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          req_address_mark,
   input  wire logic          req_frame_error,
   input  wire logic          req_tx_busy,

   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_store_valid,
   output logic [7:0]         rsp_store_index,
   output logic [7:0]         rsp_store_byte,
   output logic               rsp_frame_ready,
   output logic               rsp_poll_ready,
   output logic [8:0]         rsp_frame_length,
   output logic [1:0]         rsp_target
);

   localparam logic [8:0] BufLimit = 9'(BUF_SIZE);

   csr_type cfg;

   mafr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .csr_out          (cfg)
   );

   // Receiver state.
   phase_type  phase_ff, phase_in;
   logic [8:0] length_ff, length_in;
   target_type target_ff, target_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       store_valid_ff, store_valid_in;
   logic [7:0] store_index_ff, store_index_in;
   logic [7:0] store_byte_ff, store_byte_in;
   logic       frame_ready_ff, frame_ready_in;
   logic       poll_ready_ff, poll_ready_in;

   logic       req_accept;
   logic       aux_on;
   logic       is_primary, is_aux, is_bcast, is_end;
   logic       is_poll_primary, is_poll_aux, is_poll_own;
   logic [6:0] poll_addr;
   phase_type  cur_phase;
   logic [8:0] cur_length;

   // The result register accepts a new request when empty or being drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Address compares against the configured station addresses.
   assign aux_on          = cfg.aux_address != 7'd0;
   assign is_primary      = req_rx_byte == {1'b0, cfg.primary_address};
   assign is_aux          = aux_on && (req_rx_byte == {1'b0, cfg.aux_address});
   assign is_bcast        = req_rx_byte == cfg.bcast_addr;
   assign is_end          = req_rx_byte == cfg.end_flag;
   assign is_poll_primary = req_rx_byte == (POLL_BIT | {1'b0, cfg.primary_address});
   assign is_poll_aux     = aux_on && (req_rx_byte == (POLL_BIT | {1'b0, cfg.aux_address}));
   assign poll_addr       = (target_ff == TGT_AUX) ? cfg.aux_address : cfg.primary_address;
   assign is_poll_own     = req_rx_byte == (POLL_BIT | {1'b0, poll_addr});

   // A full buffer restarts reception before the character is handled.
   assign cur_phase  = (length_ff >= BufLimit) ? PH_IDLE : phase_ff;
   assign cur_length = (length_ff >= BufLimit) ? 9'd0 : length_ff;

   // Receiver state machine: state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         length_ff <= 9'd0;
         target_ff <= TGT_PRIMARY;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         target_ff <= target_in;
      end
   end

   // Receiver state machine: next state and result fields.
   always_comb begin
      phase_in       = phase_ff;
      length_in      = length_ff;
      target_in      = target_ff;
      store_valid_in = 1'b0;
      store_index_in = 8'd0;
      store_byte_in  = 8'd0;
      frame_ready_in = 1'b0;
      poll_ready_in  = 1'b0;
      if (req_accept) begin
         if (req_kind == KIND_RELEASE || req_frame_error || req_tx_busy) begin
            // Release, framing error or transmitter busy: drop back to idle.
            phase_in  = PH_IDLE;
            length_in = 9'd0;
         end else begin
            phase_in       = cur_phase;
            length_in      = cur_length;
            store_valid_in = 1'b1;
            store_index_in = cur_length[7:0];
            store_byte_in  = req_rx_byte;
            case (cur_phase)
               PH_IDLE: begin
                  if (req_address_mark) begin
                     if (is_primary || is_aux || is_bcast) begin
                        phase_in  = PH_FRAME;
                        length_in = 9'd1;
                        target_in = is_primary ? TGT_PRIMARY :
                                    (is_aux ? TGT_AUX : TGT_BCAST);
                     end else if (is_poll_primary) begin
                        phase_in  = PH_POLL;
                        target_in = TGT_PRIMARY;
                     end else if (is_poll_aux) begin
                        phase_in  = PH_POLL;
                        target_in = TGT_AUX;
                     end else begin
                        length_in = 9'd0;
                     end
                  end
               end
               PH_FRAME: begin
                  if (req_address_mark) begin
                     if (is_end) begin
                        length_in      = cur_length + 9'd1;
                        phase_in       = PH_WAIT;
                        frame_ready_in = 1'b1;
                     end else if (is_primary || is_bcast) begin
                        // Address mid-frame restarts the frame at index zero.
                        store_index_in = 8'd0;
                        length_in      = 9'd1;
                        target_in      = is_primary ? TGT_PRIMARY : TGT_BCAST;
                     end else if (is_aux) begin
                        store_index_in = 8'd0;
                        length_in      = 9'd1;
                        target_in      = TGT_AUX;
                     end else begin
                        phase_in  = PH_IDLE;
                        length_in = 9'd0;
                     end
                  end else begin
                     length_in = cur_length + 9'd1;
                  end
               end
               PH_POLL: begin
                  if (req_address_mark && is_poll_own) begin
                     phase_in      = PH_WAIT;
                     poll_ready_in = 1'b1;
                  end else begin
                     phase_in  = PH_IDLE;
                     length_in = 9'd0;
                  end
               end
               default: begin
                  // Waiting for release: characters are stored, state holds.
               end
            endcase
         end
      end
   end

   // Result valid: set on an accepted request, cleared when taken.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is loaded only when a request is accepted.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         store_valid_ff <= store_valid_in;
         store_index_ff <= store_index_in;
         store_byte_ff  <= store_byte_in;
         frame_ready_ff <= frame_ready_in;
         poll_ready_ff  <= poll_ready_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_store_valid  = store_valid_ff;
   assign rsp_store_index  = store_index_ff;
   assign rsp_store_byte   = store_byte_ff;
   assign rsp_frame_ready  = frame_ready_ff;
   assign rsp_poll_ready   = poll_ready_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_target       = target_ff;

   // The idle phase always carries an empty frame.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> length_ff == 9'd0)
      else $error("idle phase with nonzero frame length");

   // The frame length never runs past the buffer size.
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= BufLimit)
      else $error("frame length beyond buffer size");

   // A release request always returns the receiver to idle.
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_RELEASE |=> phase_ff == PH_IDLE && !rsp_store_valid)
      else $error("release did not return to idle");

   // A completed frame or poll leaves the receiver waiting for release.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      req_accept && (frame_ready_in || poll_ready_in) |=> phase_ff == PH_WAIT)
      else $error("completion without wait phase");

   // Frame and poll completion never coincide.
   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(frame_ready_ff && poll_ready_ff))
      else $error("frame and poll completion together");

endmodule

`default_nettype wire

>>> sim/multidrop_address_frame_receiver_tb.sv
// Self-checking testbench for the multidrop address-frame receiver.
// Drives directed and random request streams and checks each response against a predictor.
// Depends on mafr_pkg and multidrop_address_frame_receiver.
`timescale 1ns / 1ps

module multidrop_address_frame_receiver_tb;
   import mafr_pkg::*;

   localparam int RX_BUF_SIZE = 256;
   localparam int CYCLE_LIMIT = 200000;

   // Expected contents of one response.
   typedef struct packed {
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic       frame_ready;
      logic       poll_ready;
      logic [8:0] frame_length;
      target_type target;
   } rx_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_PRIMARY_ADDRESS;
   logic [7:0]    csr_wdata = 8'h00;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_kind = KIND_CHAR;
   logic [7:0]    req_rx_byte = 8'h00;
   logic          req_address_mark = 1'b0;
   logic          req_frame_error = 1'b0;
   logic          req_tx_busy = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_store_valid;
   logic [7:0]    rsp_store_index;
   logic [7:0]    rsp_store_byte;
   logic          rsp_frame_ready;
   logic          rsp_poll_ready;
   logic [8:0]    rsp_frame_length;
   logic [1:0]    rsp_target;

   // Register copies and receiver state kept by the predictor.
   logic [6:0] cfg_primary = 7'd0;
   logic [6:0] cfg_aux = 7'd0;
   logic [7:0] cfg_broadcast = 8'd0;
   logic [7:0] cfg_end_flag = 8'd0;
   phase_type  rx_phase = PH_IDLE;
   logic [8:0] rx_length = 9'd0;
   target_type rx_target = TGT_PRIMARY;

   rx_result_type pending_rx_results[$];
   int failures = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   multidrop_address_frame_receiver #(
      .BUF_SIZE(RX_BUF_SIZE)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .req_address_mark (req_address_mark),
      .req_frame_error  (req_frame_error),
      .req_tx_busy      (req_tx_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_store_valid  (rsp_store_valid),
      .rsp_store_index  (rsp_store_index),
      .rsp_store_byte   (rsp_store_byte),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_poll_ready   (rsp_poll_ready),
      .rsp_frame_length (rsp_frame_length),
      .rsp_target       (rsp_target)
   );

   always #1 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multidrop_address_frame_receiver: mismatch");
         $finish;
      end
   end

   // Advances the predicted receiver by one request and returns its response.
   function automatic rx_result_type predict_receive(input logic kind, input logic [7:0] rx_byte,
                                                    input logic mark, input logic ferr,
                                                    input logic busy);
      rx_result_type r;
      logic aux_on;
      logic is_primary;
      logic is_aux;
      logic is_broadcast;
      logic [6:0] poll_station;
      r = '0;
      aux_on = (cfg_aux != 7'd0);
      is_primary = (rx_byte == {1'b0, cfg_primary});
      is_aux = aux_on && (rx_byte == {1'b0, cfg_aux});
      is_broadcast = (rx_byte == cfg_broadcast);
      if (kind == KIND_RELEASE || ferr || busy) begin
         rx_phase = PH_IDLE;
         rx_length = 9'd0;
      end else begin
         // A full buffer restarts reception before the character is handled.
         if (rx_length >= 9'(RX_BUF_SIZE)) begin
            rx_phase = PH_IDLE;
            rx_length = 9'd0;
         end
         r.store_valid = 1'b1;
         r.store_index = rx_length[7:0];
         r.store_byte = rx_byte;
         case (rx_phase)
            PH_IDLE: begin
               if (mark) begin
                  if (is_primary || is_aux || is_broadcast) begin
                     rx_phase = PH_FRAME;
                     rx_length = 9'd1;
                     rx_target = is_primary ? TGT_PRIMARY : (is_aux ? TGT_AUX : TGT_BCAST);
                  end else if (rx_byte == ({1'b0, cfg_primary} | POLL_BIT)) begin
                     rx_phase = PH_POLL;
                     rx_target = TGT_PRIMARY;
                  end else if (aux_on && rx_byte == ({1'b0, cfg_aux} | POLL_BIT)) begin
                     rx_phase = PH_POLL;
                     rx_target = TGT_AUX;
                  end else begin
                     rx_length = 9'd0;
                  end
               end
            end
            PH_FRAME: begin
               if (!mark) begin
                  rx_length = rx_length + 9'd1;
               end else if (rx_byte == cfg_end_flag) begin
                  rx_length = rx_length + 9'd1;
                  rx_phase = PH_WAIT;
                  r.frame_ready = 1'b1;
               end else if (is_primary || is_broadcast) begin
                  // An address inside a frame starts the frame over.
                  r.store_index = 8'd0;
                  rx_length = 9'd1;
                  rx_target = is_primary ? TGT_PRIMARY : TGT_BCAST;
               end else if (is_aux) begin
                  r.store_index = 8'd0;
                  rx_length = 9'd1;
                  rx_target = TGT_AUX;
               end else begin
                  rx_phase = PH_IDLE;
                  rx_length = 9'd0;
               end
            end
            PH_POLL: begin
               poll_station = (rx_target == TGT_AUX) ? cfg_aux : cfg_primary;
               if (mark && rx_byte == ({1'b0, poll_station} | POLL_BIT)) begin
                  rx_phase = PH_WAIT;
                  r.poll_ready = 1'b1;
               end else begin
                  rx_phase = PH_IDLE;
                  rx_length = 9'd0;
               end
            end
            default: begin
            end
         endcase
      end
      r.frame_length = rx_length;
      r.target = rx_target;
      return r;
   endfunction

   function automatic void check_field(input string field_name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field_name, want, got);
         failures++;
      end
   endfunction

   // Response side: random stalls and comparison against the oldest expectation.
   always @(posedge clock) begin : result_checker
      rx_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rx_results.size() == 0) begin
               $error("response arrived with no request outstanding");
               failures++;
            end else begin
               want = pending_rx_results.pop_front();
               check_field("store_valid", 32'(want.store_valid), 32'(rsp_store_valid));
               check_field("store_index", 32'(want.store_index), 32'(rsp_store_index));
               check_field("store_byte", 32'(want.store_byte), 32'(rsp_store_byte));
               check_field("frame_ready", 32'(want.frame_ready), 32'(rsp_frame_ready));
               check_field("poll_ready", 32'(want.poll_ready), 32'(rsp_poll_ready));
               check_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
               check_field("target", 32'(want.target), 32'(rsp_target));
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Sends one request. Called just after a rising edge; leaves valid high on return.
   task automatic send_request(input logic kind, input logic [7:0] rx_byte, input logic mark,
                               input logic ferr, input logic busy);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rx_byte <= rx_byte;
      req_address_mark <= mark;
      req_frame_error <= ferr;
      req_tx_busy <= busy;
      do @(posedge clock); while (!req_ready);
      pending_rx_results.push_back(predict_receive(kind, rx_byte, mark, ferr, busy));
      items_sent++;
   endtask

   task automatic send_char(input logic [7:0] rx_byte, input logic mark);
      send_request(KIND_CHAR, rx_byte, mark, 1'b0, 1'b0);
   endtask

   // Release with random content in the fields that it ignores.
   task automatic send_release();
      send_request(KIND_RELEASE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_rx_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all four registers once the receiver has gone quiet.
   task automatic set_registers(input logic [6:0] primary, input logic [6:0] aux,
                                input logic [7:0] broadcast, input logic [7:0] end_flag_byte);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_PRIMARY_ADDRESS;
      csr_wdata <= {1'b0, primary};
      @(posedge clock);
      csr_index <= CSR_AUX_ADDRESS;
      csr_wdata <= {1'b0, aux};
      @(posedge clock);
      csr_index <= CSR_BCAST_ADDR;
      csr_wdata <= broadcast;
      @(posedge clock);
      csr_index <= CSR_END_FLAG;
      csr_wdata <= end_flag_byte;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_primary = primary;
      cfg_aux = aux;
      cfg_broadcast = broadcast;
      cfg_end_flag = end_flag_byte;
   endtask

   function automatic logic [7:0] pick_station_address();
      logic [7:0] a;
      case ($urandom_range(2))
         0: a = {1'b0, cfg_primary};
         1: a = (cfg_aux != 7'd0) ? {1'b0, cfg_aux} : {1'b0, cfg_primary};
         default: a = cfg_broadcast;
      endcase
      return a;
   endfunction

   // Frames, address restarts, polls, errors and stray bytes with all stations enabled.
   task automatic test_addressing_and_frames();
      set_registers(7'h12, 7'h34, 8'h00, 8'h7E);
      send_char(8'h5A, 1'b0);
      send_char(8'h99, 1'b1);
      send_char(8'h34, 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b1);
      send_char(8'hA5, 1'b0);
      send_char(8'h7E, 1'b1);
      send_char(8'h11, 1'b0);
      send_request(KIND_RELEASE, 8'hFF, 1'b1, 1'b1, 1'b1);
      send_char(8'hB4, 1'b1);
      send_char(8'hB4, 1'b1);
      send_release();
      send_char(8'h92, 1'b1);
      send_char(8'h12, 1'b1);
      send_char(8'h12, 1'b1);
      send_request(KIND_CHAR, 8'h40, 1'b0, 1'b1, 1'b0);
      send_char(8'h12, 1'b1);
      send_request(KIND_CHAR, 8'h40, 1'b1, 1'b0, 1'b1);
      send_char(8'h12, 1'b1);
      send_char(8'h66, 1'b1);
   endtask

   // Auxiliary station switched off; primary poll address equals the end flag.
   task automatic test_disabled_aux();
      set_registers(7'h7F, 7'h00, 8'h55, 8'hFF);
      send_char(8'h00, 1'b1);
      send_char(8'h80, 1'b1);
      send_char(8'hFF, 1'b1);
      send_char(8'hFF, 1'b1);
      send_release();
      send_char(8'h7F, 1'b1);
      send_char(8'hFF, 1'b1);
   endtask

   // Register extremes, with the end flag overlapping the primary address.
   task automatic test_register_extremes();
      set_registers(7'h00, 7'h7F, 8'hFF, 8'h00);
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_char(8'h7F, 1'b1);
      send_char(8'h00, 1'b1);
   endtask

   // Fill the buffer to its size by data and by the end flag, then overrun it.
   task automatic test_buffer_overflow();
      set_registers(7'h21, 7'h42, 8'hC3, 8'h0D);
      send_char({1'b0, cfg_primary}, 1'b1);
      repeat (RX_BUF_SIZE - 1) send_char(8'($urandom_range(255)), 1'b0);
      send_char(8'($urandom_range(255)), 1'b0);
      send_char({1'b0, cfg_primary}, 1'b1);
      repeat (RX_BUF_SIZE - 2) send_char(8'($urandom_range(255)), 1'b0);
      send_char(cfg_end_flag, 1'b1);
      send_char({1'b0, cfg_primary}, 1'b1);
      send_release();
   endtask

   // Mostly well-formed frames and polls with random content, plus noise and broken ones.
   task automatic test_random_traffic(input int item_goal);
      int start_count;
      int n;
      logic [7:0] a;
      logic [1:0] err;
      start_count = items_sent;
      set_registers(($urandom_range(3) == 0) ? ($urandom_range(1) ? 7'h7F : 7'h00)
                                             : 7'($urandom_range(127)),
                    ($urandom_range(3) == 0) ? 7'h00 : 7'($urandom_range(127)),
                    ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                             : 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      while (items_sent - start_count < item_goal) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               a = pick_station_address();
               send_char(a, 1'b1);
               n = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(8);
               repeat (n) begin
                  if ($urandom_range(19) == 0) send_char(pick_station_address(), 1'b1);
                  else send_char(8'($urandom_range(255)), 1'b0);
               end
               case ($urandom_range(7))
                  0: send_char(8'($urandom_range(255)), 1'b1);
                  1: ;
                  default: send_char(cfg_end_flag, 1'b1);
               endcase
               repeat ($urandom_range(2))
                  send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
               if ($urandom_range(4) != 0) send_release();
            end
            5, 6: begin
               a = ((cfg_aux != 7'd0) && $urandom_range(1)) ? ({1'b0, cfg_aux} | POLL_BIT)
                                                            : ({1'b0, cfg_primary} | POLL_BIT);
               send_char(a, 1'b1);
               if ($urandom_range(4) != 0) send_char(a, 1'b1);
               else send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
               if ($urandom_range(4) != 0) send_release();
            end
            7: begin
               repeat ($urandom_range(1, 4))
                  send_request($urandom_range(7) == 0, 8'($urandom_range(255)),
                               1'($urandom_range(1)),
                               $urandom_range(7) == 0, $urandom_range(7) == 0);
            end
            default: begin
               send_char(pick_station_address(), 1'b1);
               repeat ($urandom_range(3)) send_char(8'($urandom_range(255)), 1'b0);
               err = 2'($urandom_range(1, 3));
               send_request(KIND_CHAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            err[0], err[1]);
            end
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 14;
      receiver_stall_pct = 14;
      test_addressing_and_frames();
      test_disabled_aux();
      test_register_extremes();
      test_buffer_overflow();
      // Random traffic under each idling pattern.
      for (int idle_phase = 0; idle_phase < 4; idle_phase++) begin
         case (idle_phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
         repeat (2) test_random_traffic(175);
      end
      wait_until_idle();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("multidrop_address_frame_receiver: match");
      end else begin
         $display("multidrop_address_frame_receiver: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
sv/mafr_pkg.sv
sv/mafr_csr.sv
sv/multidrop_address_frame_receiver.sv
sim/multidrop_address_frame_receiver_tb.sv
